// File: src/epoch_to_calendar_date_core_assert.svh
// ----------------------------------------------------------------------------
// epoch_to_calendar_date_core assertion macros
// shared assertion forms for the calendar date core checkers
// ----------------------------------------------------------------------------
`ifndef EPOCH_TO_CALENDAR_DATE_CORE_ASSERT_SVH
`define EPOCH_TO_CALENDAR_DATE_CORE_ASSERT_SVH

// condition holds at every enabled edge
`define ECD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define ECD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ecd_pkg.sv
// ----------------------------------------------------------------------------
// ecd_pkg
// widths, constants and the month length table of the calendar date core
// ----------------------------------------------------------------------------
package ecd_pkg;

  localparam int SecondsWidth = 32;
  localparam int DayWidth     = 5;
  localparam int MonthWidth   = 4;
  localparam int YearWidth    = 12;
  localparam int HourWidth    = 5;
  localparam int MinuteWidth  = 6;
  localparam int SecondWidth  = 6;

  localparam int DaysWidth    = 16;
  localparam int TodWidth     = 17;
  localparam int CntWidth     = 4;

  localparam logic [SecondsWidth-1:0] DAY_DIV_INIT  = SecondsWidth'(86400) << 15;
  localparam logic [CntWidth-1:0]     DAY_STEPS     = CntWidth'(15);
  localparam logic [SecondsWidth-1:0] HOUR_DIV_INIT = SecondsWidth'(3600) << 4;
  localparam logic [CntWidth-1:0]     HOUR_STEPS    = CntWidth'(4);
  localparam logic [SecondsWidth-1:0] MIN_DIV_INIT  = SecondsWidth'(60) << 5;
  localparam logic [CntWidth-1:0]     MIN_STEPS     = CntWidth'(5);

  localparam logic [YearWidth-1:0]  EPOCH_YEAR   = YearWidth'(1970);
  localparam logic [6:0]            EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]            EPOCH_MOD400 = 9'd370;
  localparam logic [MonthWidth-1:0] LAST_MONTH   = MonthWidth'(11);

  function automatic logic [4:0] month_len(input logic [MonthWidth-1:0] idx,
                                           input logic leap);
    logic [4:0] len;
    case (idx)
      4'd1:                len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8,
      4'd10:               len = 5'd30;
      default:             len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// File: src/ecd_if.sv
// ----------------------------------------------------------------------------
// ecd interfaces
// input and result channels of the calendar date core
// ----------------------------------------------------------------------------
interface ecd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [ecd_pkg::SecondsWidth-1:0]     epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ecd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [ecd_pkg::DayWidth-1:0]         day_of_month;
  logic [ecd_pkg::MonthWidth-1:0]       month_number;
  logic [ecd_pkg::YearWidth-1:0]        year_number;
  logic [ecd_pkg::HourWidth-1:0]        hour_of_day;
  logic [ecd_pkg::MinuteWidth-1:0]      minute_of_hour;
  logic [ecd_pkg::SecondWidth-1:0]      second_of_minute;

  modport source (output valid, output day_of_month, output month_number,
                  output year_number, output hour_of_day, output minute_of_hour,
                  output second_of_minute, input ready);
  modport sink   (input valid, input day_of_month, input month_number,
                  input year_number, input hour_of_day, input minute_of_hour,
                  input second_of_minute, output ready);
endinterface

// File: src/epoch_to_calendar_date_core.sv
// ----------------------------------------------------------------------------
// epoch_to_calendar_date_core
// seconds since 1970-01-01 00:00:00 to Gregorian date and time of day
// ----------------------------------------------------------------------------
// One beat in, one beat out. All arithmetic runs through a single 32-bit
// compare-subtract unit under a small sequencer: 16 steps of long division
// by 86400, one step per whole year from 1970 (up to 137 compares), one step
// per month (up to 12), then 5 steps for the hour and 6 for minute and
// second. The time from acceptance to result is set almost entirely by
// the year count. The block takes a new beat only when idle; a finished
// result sits in the output register, so a new beat can be accepted while
// it waits.
module epoch_to_calendar_date_core (
  input  logic      clk,
  input  logic      rst_n,
  ecd_in_if.sink    in_ch,
  ecd_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DAYS,
    S_YEAR,
    S_MONTH,
    S_HOUR,
    S_MIN,
    S_DONE
  } state_t;

  state_t                                state_r;
  logic [ecd_pkg::SecondsWidth-1:0]      acc_r;
  logic [ecd_pkg::SecondsWidth-1:0]      div_r;
  logic [ecd_pkg::DaysWidth-1:0]         quo_r;
  logic [ecd_pkg::CntWidth-1:0]          cnt_r;
  logic [ecd_pkg::TodWidth-1:0]          tod_r;
  logic [ecd_pkg::YearWidth-1:0]         year_r;
  logic [6:0]                            ymod100_r;
  logic [8:0]                            ymod400_r;
  logic [ecd_pkg::MonthWidth-1:0]        month_r;
  logic [ecd_pkg::DayWidth-1:0]          day_r;
  logic [ecd_pkg::HourWidth-1:0]         hour_r;
  logic [ecd_pkg::MinuteWidth-1:0]       min_r;
  logic [ecd_pkg::SecondWidth-1:0]       sec_r;

  logic                                  out_valid_r;
  logic [ecd_pkg::DayWidth-1:0]          out_day_r;
  logic [ecd_pkg::MonthWidth-1:0]        out_month_r;
  logic [ecd_pkg::YearWidth-1:0]         out_year_r;
  logic [ecd_pkg::HourWidth-1:0]         out_hour_r;
  logic [ecd_pkg::MinuteWidth-1:0]       out_min_r;
  logic [ecd_pkg::SecondWidth-1:0]       out_sec_r;

  logic                                  leap;
  logic [ecd_pkg::SecondsWidth-1:0]      operand;
  logic [ecd_pkg::SecondsWidth:0]        diff;
  logic                                  ge;
  logic [ecd_pkg::SecondsWidth-1:0]      rem_nxt;
  logic [ecd_pkg::DaysWidth-1:0]         quo_nxt;
  logic                                  out_load;

  assign leap = (ymod400_r == 9'd0) || ((year_r[1:0] == 2'd0) && (ymod100_r != 7'd0));

  // shared compare-subtract unit
  always_comb begin
    unique case (state_r)
      S_YEAR:  operand = leap ? ecd_pkg::SecondsWidth'(366) : ecd_pkg::SecondsWidth'(365);
      S_MONTH: operand = ecd_pkg::SecondsWidth'(ecd_pkg::month_len(month_r, leap));
      default: operand = div_r;
    endcase
  end

  assign diff    = {1'b0, acc_r} - {1'b0, operand};
  assign ge      = !diff[ecd_pkg::SecondsWidth];
  assign rem_nxt = ge ? diff[ecd_pkg::SecondsWidth-1:0] : acc_r;
  assign quo_nxt = {quo_r[ecd_pkg::DaysWidth-2:0], ge};

  // result register takes a new beat
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.day_of_month     = out_day_r;
  assign out_ch.month_number     = out_month_r;
  assign out_ch.year_number      = out_year_r;
  assign out_ch.hour_of_day      = out_hour_r;
  assign out_ch.minute_of_hour   = out_min_r;
  assign out_ch.second_of_minute = out_sec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            acc_r   <= in_ch.epoch_seconds;
            div_r   <= ecd_pkg::DAY_DIV_INIT;
            cnt_r   <= ecd_pkg::DAY_STEPS;
            quo_r   <= '0;
            state_r <= S_DAYS;
          end
        end
        S_DAYS: begin
          div_r <= div_r >> 1;
          cnt_r <= cnt_r - 1'b1;
          quo_r <= quo_nxt;
          if (cnt_r == '0) begin
            tod_r     <= rem_nxt[ecd_pkg::TodWidth-1:0];
            acc_r     <= ecd_pkg::SecondsWidth'(quo_nxt);
            year_r    <= ecd_pkg::EPOCH_YEAR;
            ymod100_r <= ecd_pkg::EPOCH_MOD100;
            ymod400_r <= ecd_pkg::EPOCH_MOD400;
            state_r   <= S_YEAR;
          end else begin
            acc_r <= rem_nxt;
          end
        end
        S_YEAR: begin
          if (ge) begin
            acc_r     <= diff[ecd_pkg::SecondsWidth-1:0];
            year_r    <= year_r + 1'b1;
            ymod100_r <= (ymod100_r == 7'd99) ? 7'd0 : ymod100_r + 1'b1;
            ymod400_r <= (ymod400_r == 9'd399) ? 9'd0 : ymod400_r + 1'b1;
          end else begin
            month_r <= '0;
            state_r <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (ge && (month_r != ecd_pkg::LAST_MONTH)) begin
            acc_r   <= diff[ecd_pkg::SecondsWidth-1:0];
            month_r <= month_r + 1'b1;
          end else begin
            day_r   <= acc_r[ecd_pkg::DayWidth-1:0] + 1'b1;
            acc_r   <= ecd_pkg::SecondsWidth'(tod_r);
            div_r   <= ecd_pkg::HOUR_DIV_INIT;
            cnt_r   <= ecd_pkg::HOUR_STEPS;
            quo_r   <= '0;
            state_r <= S_HOUR;
          end
        end
        S_HOUR: begin
          acc_r <= rem_nxt;
          if (cnt_r == '0) begin
            hour_r  <= quo_nxt[ecd_pkg::HourWidth-1:0];
            div_r   <= ecd_pkg::MIN_DIV_INIT;
            cnt_r   <= ecd_pkg::MIN_STEPS;
            quo_r   <= '0;
            state_r <= S_MIN;
          end else begin
            div_r <= div_r >> 1;
            cnt_r <= cnt_r - 1'b1;
            quo_r <= quo_nxt;
          end
        end
        S_MIN: begin
          div_r <= div_r >> 1;
          cnt_r <= cnt_r - 1'b1;
          quo_r <= quo_nxt;
          acc_r <= rem_nxt;
          if (cnt_r == '0) begin
            min_r   <= quo_nxt[ecd_pkg::MinuteWidth-1:0];
            sec_r   <= rem_nxt[ecd_pkg::SecondWidth-1:0];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_day_r   <= day_r;
            out_month_r <= month_r + 1'b1;
            out_year_r  <= year_r;
            out_hour_r  <= hour_r;
            out_min_r   <= min_r;
            out_sec_r   <= sec_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/ecd_chk.sv
// ----------------------------------------------------------------------------
// ecd_chk
// port-level checks of the calendar date core, bound to the top level
// ----------------------------------------------------------------------------
`include "epoch_to_calendar_date_core_assert.svh"

module ecd_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [ecd_pkg::DayWidth-1:0]      day_of_month,
  input logic [ecd_pkg::MonthWidth-1:0]    month_number,
  input logic [ecd_pkg::HourWidth-1:0]     hour_of_day,
  input logic [ecd_pkg::MinuteWidth-1:0]   minute_of_hour,
  input logic [ecd_pkg::SecondWidth-1:0]   second_of_minute
);

  logic date_ok;
  logic time_ok;

  assign date_ok = !out_valid || (month_number >= 4'd1 && month_number <= 4'd12
                                  && day_of_month >= 5'd1);
  assign time_ok = !out_valid || (hour_of_day < 5'd24 && minute_of_hour < 6'd60
                                  && second_of_minute < 6'd60);

  // busy after taking a beat
  `ECD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")

  // a stalled result stays
  `ECD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

  `ECD_ASSERT_ALWAYS(a_date_range, date_ok, "date out of range")

  `ECD_ASSERT_ALWAYS(a_time_range, time_ok, "time out of range")

endmodule

bind epoch_to_calendar_date_core ecd_chk u_ecd_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .day_of_month     (out_ch.day_of_month),
  .month_number     (out_ch.month_number),
  .hour_of_day      (out_ch.hour_of_day),
  .minute_of_hour   (out_ch.minute_of_hour),
  .second_of_minute (out_ch.second_of_minute)
);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench for epoch_to_calendar_date_core
// Drives epoch second counts through the input channel. A local predictor
// works out the Gregorian date and time of day for every accepted beat.
// The monitor compares each result beat with the oldest prediction, field by
// field. Directed values cover the field extremes, leap and century years,
// Feb 29 and Dec 31. A random part then aims at year and month edges.
// Sender and receiver stall at random in the first two of three phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned FIRST_YEAR    = 1970;
  localparam int unsigned LAST_YEAR     = 2106;
  localparam int unsigned FEBRUARY      = 1;
  localparam int unsigned DECEMBER      = 11;
  localparam int RANDOM_ITEMS = 1300;
  localparam int PHASE_LEN    = 430;
  localparam int DRAIN_CYCLES = 250;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [ecd_pkg::DayWidth-1:0]    day;
    logic [ecd_pkg::MonthWidth-1:0]  month;
    logic [ecd_pkg::YearWidth-1:0]   year;
    logic [ecd_pkg::HourWidth-1:0]   hour;
    logic [ecd_pkg::MinuteWidth-1:0] minute;
    logic [ecd_pkg::SecondWidth-1:0] second;
  } cal_date_t;

  logic clk = 1'b0;
  logic rst_n;

  ecd_in_if  in_ch ();
  ecd_out_if out_ch ();

  epoch_to_calendar_date_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [ecd_pkg::SecondsWidth-1:0] epoch_backlog [$];
  cal_date_t                        expected_dates [$];
  int                               n_directed;
  int                               beats_in;
  int                               beats_out;
  int                               errors;
  int                               feb29_seen;
  int                               cycle_count;
  bit                               years_seen [int];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit is_leap_year(input int unsigned yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  function automatic cal_date_t predict_date(input logic [ecd_pkg::SecondsWidth-1:0] secs);
    int unsigned days;
    int unsigned tod;
    int unsigned yr;
    int unsigned mon;
    int unsigned mlen;
    bit          leap;
    cal_date_t   d;
    days = secs / SECS_PER_DAY;
    tod  = secs % SECS_PER_DAY;
    yr   = FIRST_YEAR;
    while (days >= (is_leap_year(yr) ? 366 : 365)) begin
      days -= is_leap_year(yr) ? 366 : 365;
      yr++;
    end
    leap = is_leap_year(yr);
    mon  = 0;
    while (mon < DECEMBER) begin
      case (mon)
        FEBRUARY:    mlen = leap ? 29 : 28;
        3, 5, 8, 10: mlen = 30;
        default:     mlen = 31;
      endcase
      if (days < mlen) break;
      days -= mlen;
      mon++;
    end
    d.day    = ecd_pkg::DayWidth'(days + 1);
    d.month  = ecd_pkg::MonthWidth'(mon + 1);
    d.year   = ecd_pkg::YearWidth'(yr);
    d.hour   = ecd_pkg::HourWidth'(tod / SECS_PER_HOUR);
    d.minute = ecd_pkg::MinuteWidth'((tod % SECS_PER_HOUR) / 60);
    d.second = ecd_pkg::SecondWidth'((tod % SECS_PER_HOUR) % 60);
    return d;
  endfunction

  // receiver and sender stall percentages per phase
  function automatic int idle_pct(input int beats, input bit sink_side);
    if (beats < n_directed + PHASE_LEN) return sink_side ? 62 : 27;
    if (beats < n_directed + 2 * PHASE_LEN) return sink_side ? 27 : 62;
    return 0;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.epoch_seconds <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_dates = {expected_dates, predict_date(in_ch.epoch_seconds)};
        beats_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (epoch_backlog.size() != 0
            && !((beats_in == n_directed || beats_in == n_directed + PHASE_LEN
                  || beats_in == n_directed + 2 * PHASE_LEN)
                 && expected_dates.size() != 0)
            && $urandom_range(99) >= idle_pct(beats_in, 1'b0)) begin
          in_ch.valid         <= 1'b1;
          in_ch.epoch_seconds <= epoch_backlog.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cal_date_t got;
    cal_date_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.day    = out_ch.day_of_month;
        got.month  = out_ch.month_number;
        got.year   = out_ch.year_number;
        got.hour   = out_ch.hour_of_day;
        got.minute = out_ch.minute_of_hour;
        got.second = out_ch.second_of_minute;
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %0d-%0d-%0d %0d:%0d:%0d",
                   $time, got.year, got.month, got.day, got.hour, got.minute, got.second);
          errors++;
        end else begin
          want = expected_dates.pop_front();
          check_field("day_of_month", 16'(want.day), 16'(got.day));
          check_field("month_number", 16'(want.month), 16'(got.month));
          check_field("year_number", 16'(want.year), 16'(got.year));
          check_field("hour_of_day", 16'(want.hour), 16'(got.hour));
          check_field("minute_of_hour", 16'(want.minute), 16'(got.minute));
          check_field("second_of_minute", 16'(want.second), 16'(got.second));
        end
        beats_out++;
        years_seen[int'(got.year)] = 1'b1;
        if (got.month == ecd_pkg::MonthWidth'(FEBRUARY + 1)
            && got.day == ecd_pkg::DayWidth'(29)) feb29_seen++;
      end
      out_ch.ready <= ($urandom_range(99) >= idle_pct(beats_out, 1'b1));
    end
  end

  // stimulus and end of run
  initial begin
    longint unsigned jan1;
    longint unsigned s;
    int unsigned     yr;
    int unsigned     pick;
    epoch_backlog = '{
      32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999, 32'd68169600, 32'd94521600, 32'd94607999, 32'd94608000,
      32'd951782400, 32'd951868800, 32'd978220800, 32'd4107456000, 32'd4107542400,
      32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555
    };
    n_directed = epoch_backlog.size();
    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      yr   = $urandom_range(LAST_YEAR, FIRST_YEAR + 1);
      jan1 = 0;
      for (int unsigned y = FIRST_YEAR; y < yr; y++) jan1 += is_leap_year(y) ? 366 : 365;
      jan1 *= SECS_PER_DAY;
      if (pick < 25) begin
        s = $urandom;
      end else if (pick < 50) begin
        // around new year
        s = jan1 + $urandom_range(2 * SECS_PER_DAY) - SECS_PER_DAY;
      end else if (pick < 70) begin
        // end of february, start of march
        s = jan1 + $urandom_range(61, 57) * SECS_PER_DAY + $urandom_range(SECS_PER_DAY - 1);
      end else if (pick < 85) begin
        // last two days of the year before, leap or not
        s = jan1 - SECS_PER_DAY * $urandom_range(2, 1) + $urandom_range(SECS_PER_DAY - 1);
      end else begin
        s = $urandom_range(200000);
      end
      if (s > 64'hFFFF_FFFF) s = $urandom;
      epoch_backlog = {epoch_backlog, s[31:0]};
    end

    wait (rst_n === 1'b1);
    while (epoch_backlog.size() != 0 || in_ch.valid || expected_dates.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d epoch counts (%0d directed) over %0d distinct years",
             beats_out, n_directed, years_seen.num());
    $display("february 29 results: %0d, mismatches: %0d", feb29_seen, errors);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d results still pending",
             $time, cycle_count, expected_dates.size());
    $display("testbench failed");
    $finish;
  end

endmodule
